[hw/rtl/ttbe_pkg.sv]
// Shared types and constants for the terminal text buffer editor.
// No dependencies; used by ttbe_engine, terminal_text_buffer_editor, the checkers and the testbench.
package ttbe_pkg;

    localparam int POS_W      = 11;
    localparam int STORE_SIZE = 1 << POS_W;
    localparam int MEM_AW     = POS_W + 1;

    localparam logic [7:0] CH_NL = 8'h0A;

    localparam logic [3:0] CMD_WRITE     = 4'd0;
    localparam logic [3:0] CMD_NEWLINE   = 4'd1;
    localparam logic [3:0] CMD_CR        = 4'd2;
    localparam logic [3:0] CMD_BACKSPACE = 4'd3;
    localparam logic [3:0] CMD_ERASE_DSP = 4'd4;
    localparam logic [3:0] CMD_ERASE_LN  = 4'd5;
    localparam logic [3:0] CMD_SET       = 4'd6;
    localparam logic [3:0] CMD_UP        = 4'd7;
    localparam logic [3:0] CMD_DOWN      = 4'd8;
    localparam logic [3:0] CMD_FWD       = 4'd9;
    localparam logic [3:0] CMD_BACK      = 4'd10;
    localparam logic [3:0] CMD_ALT       = 4'd11;
    localparam logic [3:0] CMD_CLEAR     = 4'd12;
    localparam logic [3:0] CMD_READ      = 4'd13;

    localparam logic [1:0] ERASE_TO_END    = 2'd0;
    localparam logic [1:0] ERASE_TO_CURSOR = 2'd1;
    localparam logic [1:0] ERASE_WHOLE     = 2'd2;
    localparam logic [1:0] ERASE_DISPLAY   = 2'd3;

    typedef logic [POS_W-1:0] pos_t;

    typedef enum logic [2:0] {
        OP_READ,
        OP_WRITE,
        OP_SCAN_FWD,
        OP_SCAN_BACK,
        OP_MOVE_DN,
        OP_MOVE_UP
    } eng_op_t;

    // a/b: first/limit position, d: move distance for OP_MOVE_DN
    typedef struct packed {
        logic       start;
        eng_op_t    op;
        logic       sel;
        pos_t       a;
        pos_t       b;
        pos_t       d;
        logic [7:0] wdata;
    } eng_req_t;

    typedef struct packed {
        logic       done;
        pos_t       pos;
        logic [7:0] data;
    } eng_rsp_t;

endpackage

[hw/rtl/ttbe_engine.sv]
// Character store memory and its sequential access unit: single reads and
// writes, newline scans in both directions and block moves. Uses ttbe_pkg.
module ttbe_engine (
    input  logic              aclk,
    input  logic              aresetn,
    input  ttbe_pkg::eng_req_t req_i,
    output ttbe_pkg::eng_rsp_t rsp_o
);
    import ttbe_pkg::*;

    typedef enum logic [2:0] {E_IDLE, E_READ, E_FWD, E_BACK, E_DN, E_UP} est_t;

    est_t       state_reg;
    logic       sel_reg;
    pos_t       lo_reg, hi_reg, dist_reg, pend_reg;
    logic       done_reg;
    pos_t       pos_reg;
    logic [7:0] data_reg;

    logic [7:0] mem [2*STORE_SIZE];
    logic [7:0] rdata_reg;

    logic       mem_sel;
    pos_t       rd_pos, wr_pos;
    logic       wr_en;
    logic [7:0] wr_data;

    always_comb begin
        mem_sel = sel_reg;
        rd_pos  = pend_reg;
        wr_en   = 1'b0;
        wr_pos  = pend_reg;
        wr_data = rdata_reg;
        case (state_reg)
            E_IDLE: begin
                mem_sel = req_i.sel;
                if (req_i.start) begin
                    case (req_i.op)
                        OP_READ:      rd_pos = req_i.a;
                        OP_WRITE: begin
                            wr_en   = 1'b1;
                            wr_pos  = req_i.a;
                            wr_data = req_i.wdata;
                        end
                        OP_SCAN_FWD:  rd_pos = req_i.a;
                        OP_SCAN_BACK: rd_pos = req_i.a - 1'b1;
                        OP_MOVE_DN:   rd_pos = req_i.a;
                        OP_MOVE_UP:   rd_pos = req_i.b - 1'b1;
                        default:      rd_pos = req_i.a;
                    endcase
                end
            end
            E_FWD:  rd_pos = pend_reg + 1'b1;
            E_BACK: rd_pos = pend_reg - 1'b1;
            E_DN: begin
                wr_en  = 1'b1;
                wr_pos = pend_reg - dist_reg;
                rd_pos = pend_reg + 1'b1;
            end
            E_UP: begin
                wr_en  = 1'b1;
                wr_pos = pend_reg + 1'b1;
                rd_pos = pend_reg - 1'b1;
            end
            default: rd_pos = pend_reg;
        endcase
    end

    // reads run ahead speculatively; in the move states the read address never collides with the write
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[{mem_sel, wr_pos}] <= wr_data;
        end
        rdata_reg <= mem[{mem_sel, rd_pos}];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= E_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                E_IDLE: begin
                    if (req_i.start) begin
                        sel_reg  <= req_i.sel;
                        lo_reg   <= req_i.a;
                        hi_reg   <= req_i.b;
                        dist_reg <= req_i.d;
                        case (req_i.op)
                            OP_READ: state_reg <= E_READ;
                            OP_WRITE: done_reg <= 1'b1;
                            OP_SCAN_FWD: begin
                                if (req_i.a >= req_i.b) begin
                                    done_reg <= 1'b1;
                                    pos_reg  <= req_i.b;
                                end else begin
                                    pend_reg  <= req_i.a;
                                    state_reg <= E_FWD;
                                end
                            end
                            OP_SCAN_BACK: begin
                                if (req_i.a == '0) begin
                                    done_reg <= 1'b1;
                                    pos_reg  <= '0;
                                end else begin
                                    pend_reg  <= req_i.a - 1'b1;
                                    state_reg <= E_BACK;
                                end
                            end
                            OP_MOVE_DN: begin
                                if (req_i.a >= req_i.b) begin
                                    done_reg <= 1'b1;
                                end else begin
                                    pend_reg  <= req_i.a;
                                    state_reg <= E_DN;
                                end
                            end
                            OP_MOVE_UP: begin
                                if (req_i.a >= req_i.b) begin
                                    done_reg <= 1'b1;
                                end else begin
                                    pend_reg  <= req_i.b - 1'b1;
                                    state_reg <= E_UP;
                                end
                            end
                            default: done_reg <= 1'b1;
                        endcase
                    end
                end
                E_READ: begin
                    data_reg  <= rdata_reg;
                    done_reg  <= 1'b1;
                    state_reg <= E_IDLE;
                end
                E_FWD: begin
                    if (rdata_reg == CH_NL) begin
                        pos_reg   <= pend_reg;
                        done_reg  <= 1'b1;
                        state_reg <= E_IDLE;
                    end else if ({1'b0, pend_reg} + 1'b1 >= {1'b0, hi_reg}) begin
                        pos_reg   <= hi_reg;
                        done_reg  <= 1'b1;
                        state_reg <= E_IDLE;
                    end else begin
                        pend_reg <= pend_reg + 1'b1;
                    end
                end
                E_BACK: begin
                    if (rdata_reg == CH_NL) begin
                        pos_reg   <= pend_reg + 1'b1;
                        done_reg  <= 1'b1;
                        state_reg <= E_IDLE;
                    end else if (pend_reg == '0) begin
                        pos_reg   <= '0;
                        done_reg  <= 1'b1;
                        state_reg <= E_IDLE;
                    end else begin
                        pend_reg <= pend_reg - 1'b1;
                    end
                end
                E_DN: begin
                    if ({1'b0, pend_reg} + 1'b1 >= {1'b0, hi_reg}) begin
                        done_reg  <= 1'b1;
                        state_reg <= E_IDLE;
                    end else begin
                        pend_reg <= pend_reg + 1'b1;
                    end
                end
                E_UP: begin
                    if (pend_reg <= lo_reg) begin
                        done_reg  <= 1'b1;
                        state_reg <= E_IDLE;
                    end else begin
                        pend_reg <= pend_reg - 1'b1;
                    end
                end
                default: state_reg <= E_IDLE;
            endcase
        end
    end

    assign rsp_o.done = done_reg;
    assign rsp_o.pos  = pos_reg;
    assign rsp_o.data = data_reg;

endmodule

[hw/rtl/terminal_text_buffer_editor.sv]
// Terminal text buffer editor top level: command sequencer and per-store
// length, cursor and line-start registers. Uses ttbe_pkg and ttbe_engine.
//
// One request on the s_ channel carries a command and its arguments; exactly
// one result per request leaves on the m_ channel with the active store's
// length, cursor, line start, the character read and the active-store flag.
// Requests are handled one at a time; s_ready is high while the sequencer is
// idle, including while a finished result still waits in the output register.
// Carriage return, back, clear, store-select and unused commands pass only
// through the dispatch and finish states; the next request is taken once the
// sequencer is back in idle.
// Commands that touch the store run on the memory unit, one character per
// cycle: line scans, inserts and deletions step through the characters in
// turn, and an insert into a full store first drops the oldest character.
// Set cursor scans one line per row and appends a newline per missing row.
// A write ends with a scan back to the line start. The store memory has one
// port pair, which bounds all of these at one character per cycle.
// Reset (synchronous, aresetn low) empties both stores, selects the main
// store and drops any pending result; memory contents are not cleared.
// When the receiver stalls, the result is held and the next request is not
// finished until the output register frees.
module terminal_text_buffer_editor (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [3:0]                s_cmd,
    input  logic [7:0]                s_ch,
    input  logic [1:0]                s_erase_mode,
    input  logic [ttbe_pkg::POS_W-1:0] s_row,
    input  logic [ttbe_pkg::POS_W-1:0] s_col,
    input  logic [ttbe_pkg::POS_W-1:0] s_count,
    input  logic                      s_alt_enable,
    input  logic                      s_clear_on_enter,
    input  logic [ttbe_pkg::POS_W-1:0] s_read_index,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [ttbe_pkg::POS_W-1:0] m_length,
    output logic [ttbe_pkg::POS_W-1:0] m_cursor_pos,
    output logic [ttbe_pkg::POS_W-1:0] m_line_begin,
    output logic [7:0]                m_read_data,
    output logic                      m_alt_active
);
    import ttbe_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE, ST_DISPATCH, ST_WAIT, ST_REFRESH, ST_REFRESH_DONE, ST_FINISH,
        ST_INS, ST_INS_DROP, ST_INS_SHIFT, ST_INS_WR,
        ST_WR_CHK, ST_WR_INS_DONE, ST_WR_APP_DONE,
        ST_NL_SCAN, ST_NL_INS_DONE, ST_BS_DONE,
        ST_EL_SCAN, ST_CUT, ST_CUT_DONE,
        ST_SET_LOOP, ST_SET_STEP, ST_SET_APP,
        ST_PLACE, ST_PLACE_DONE,
        ST_UP_LOOP, ST_UP_CHK, ST_UP_STEP,
        ST_DN_LOOP, ST_DN_STEP, ST_FWD_DONE, ST_RD_DONE
    } state_t;

    state_t     state_reg, after_reg, ins_ret_reg;
    eng_req_t   eng_req_reg;
    eng_rsp_t   eng_rsp;

    logic       sel_reg;
    pos_t       main_len_reg, main_cur_reg, main_lb_reg;
    pos_t       alt_len_reg, alt_cur_reg, alt_lb_reg;

    logic [3:0] cmd_reg;
    logic [7:0] ch_reg, rd_reg, ins_ch_reg;
    logic [1:0] mode_reg;
    logic       en_reg, clr_reg;
    pos_t       ridx_reg, col_reg, cnt_reg;
    pos_t       blen_reg, bcur_reg, blb_reg;
    pos_t       s_reg, e_reg, ival_reg, rcnt_reg, ins_pos_reg;

    logic       m_valid_reg, m_alt_reg;
    pos_t       m_len_reg, m_cur_reg, m_lb_reg;
    logic [7:0] m_rd_reg;

    ttbe_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req_i   (eng_req_reg),
        .rsp_o   (eng_rsp)
    );

    function automatic eng_req_t mk_req(eng_op_t op, logic sel, pos_t a, pos_t b, pos_t d,
                                        logic [7:0] w);
        eng_req_t r;
        r.start = 1'b1;
        r.op    = op;
        r.sel   = sel;
        r.a     = a;
        r.b     = b;
        r.d     = d;
        r.wdata = w;
        return r;
    endfunction

    // combinational helpers for the sequencer
    logic [POS_W:0] fwd_sum;
    pos_t place_w, place_c, cut_len, up_j, ref_cur, ival_new;
    pos_t ed_s, ed_e, el_s, el_e;

    always_comb begin
        fwd_sum  = {1'b0, bcur_reg} + {1'b0, cnt_reg};
        place_w  = (eng_rsp.pos >= s_reg) ? eng_rsp.pos - s_reg : '0;
        place_c  = (ival_reg > place_w) ? place_w : ival_reg;
        cut_len  = e_reg - s_reg;
        // previous line start: skip the break that ends the line above
        up_j     = (eng_rsp.data == CH_NL) ? s_reg - 2'd2 : s_reg - 1'b1;
        ref_cur  = (bcur_reg > blen_reg) ? blen_reg : bcur_reg;
        ival_new = (bcur_reg >= blb_reg) ? bcur_reg - blb_reg : '0;
        if (mode_reg == ERASE_TO_CURSOR) begin
            ed_s = '0;
            ed_e = bcur_reg;
        end else begin
            ed_s = bcur_reg;
            ed_e = blen_reg;
        end
        if (ed_e > blen_reg) ed_e = blen_reg;
        case (mode_reg)
            ERASE_TO_CURSOR: begin
                el_s = blb_reg;
                el_e = bcur_reg;
            end
            ERASE_WHOLE: begin
                el_s = blb_reg;
                el_e = eng_rsp.pos;
            end
            default: begin
                el_s = bcur_reg;
                el_e = eng_rsp.pos;
            end
        endcase
        if (el_e > blen_reg) el_e = blen_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            eng_req_reg.start <= 1'b0;
            m_valid_reg       <= 1'b0;
            sel_reg           <= 1'b0;
            main_len_reg      <= '0;
            main_cur_reg      <= '0;
            main_lb_reg       <= '0;
            alt_len_reg       <= '0;
            alt_cur_reg       <= '0;
            alt_lb_reg        <= '0;
        end else begin
            eng_req_reg.start <= 1'b0;
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        cmd_reg  <= s_cmd;
                        ch_reg   <= s_ch;
                        mode_reg <= s_erase_mode;
                        s_reg    <= '0;
                        rcnt_reg <= (s_row == '0) ? '0 : s_row - 1'b1;
                        col_reg  <= (s_col == '0) ? '0 : s_col - 1'b1;
                        cnt_reg  <= (s_count == '0) ? pos_t'(1) : s_count;
                        en_reg   <= s_alt_enable;
                        clr_reg  <= s_clear_on_enter;
                        ridx_reg <= s_read_index;
                        rd_reg   <= '0;
                        blen_reg <= sel_reg ? alt_len_reg : main_len_reg;
                        bcur_reg <= sel_reg ? alt_cur_reg : main_cur_reg;
                        blb_reg  <= sel_reg ? alt_lb_reg  : main_lb_reg;
                        state_reg <= ST_DISPATCH;
                    end
                end
                ST_DISPATCH: begin
                    state_reg <= ST_FINISH;
                    case (cmd_reg)
                        CMD_WRITE: begin
                            ins_ch_reg <= ch_reg;
                            if (bcur_reg < blen_reg) begin
                                eng_req_reg <= mk_req(OP_READ, sel_reg, bcur_reg, '0, '0, '0);
                                after_reg   <= ST_WR_CHK;
                                state_reg   <= ST_WAIT;
                            end else begin
                                ins_pos_reg <= blen_reg;
                                ins_ret_reg <= ST_WR_APP_DONE;
                                state_reg   <= ST_INS;
                            end
                        end
                        CMD_NEWLINE: begin
                            eng_req_reg <= mk_req(OP_SCAN_FWD, sel_reg, blb_reg, blen_reg,
                                                  '0, '0);
                            after_reg   <= ST_NL_SCAN;
                            state_reg   <= ST_WAIT;
                        end
                        CMD_CR: bcur_reg <= blb_reg;
                        CMD_BACKSPACE: begin
                            if (bcur_reg != '0 && bcur_reg > blb_reg && bcur_reg <= blen_reg)
                            begin
                                eng_req_reg <= mk_req(OP_MOVE_DN, sel_reg, bcur_reg, blen_reg,
                                                      pos_t'(1), '0);
                                after_reg   <= ST_BS_DONE;
                                state_reg   <= ST_WAIT;
                            end
                        end
                        CMD_ERASE_DSP: begin
                            if (mode_reg == ERASE_WHOLE || mode_reg == ERASE_DISPLAY) begin
                                blen_reg <= '0;
                                bcur_reg <= '0;
                                blb_reg  <= '0;
                            end else if (ed_e > ed_s) begin
                                s_reg     <= ed_s;
                                e_reg     <= ed_e;
                                state_reg <= ST_CUT;
                            end
                        end
                        CMD_ERASE_LN: begin
                            eng_req_reg <= mk_req(OP_SCAN_FWD, sel_reg, blb_reg, blen_reg,
                                                  '0, '0);
                            after_reg   <= ST_EL_SCAN;
                            state_reg   <= ST_WAIT;
                        end
                        CMD_SET: begin
                            ival_reg  <= col_reg;
                            state_reg <= ST_SET_LOOP;
                        end
                        CMD_UP: begin
                            ival_reg  <= ival_new;
                            s_reg     <= blb_reg;
                            rcnt_reg  <= cnt_reg;
                            state_reg <= ST_UP_LOOP;
                        end
                        CMD_DOWN: begin
                            ival_reg  <= ival_new;
                            s_reg     <= blb_reg;
                            rcnt_reg  <= cnt_reg;
                            state_reg <= ST_DN_LOOP;
                        end
                        CMD_FWD: begin
                            eng_req_reg <= mk_req(OP_SCAN_FWD, sel_reg, blb_reg, blen_reg,
                                                  '0, '0);
                            after_reg   <= ST_FWD_DONE;
                            state_reg   <= ST_WAIT;
                        end
                        CMD_BACK: begin
                            if (bcur_reg > blb_reg) begin
                                bcur_reg <= (cnt_reg > bcur_reg - blb_reg) ? blb_reg
                                                                           : bcur_reg - cnt_reg;
                            end
                        end
                        CMD_ALT: begin
                            // save the active store, then load the selected one
                            if (sel_reg) begin
                                alt_len_reg <= blen_reg;
                                alt_cur_reg <= bcur_reg;
                                alt_lb_reg  <= blb_reg;
                            end else begin
                                main_len_reg <= blen_reg;
                                main_cur_reg <= bcur_reg;
                                main_lb_reg  <= blb_reg;
                            end
                            sel_reg <= en_reg;
                            if (en_reg) begin
                                if (clr_reg) begin
                                    blen_reg <= '0;
                                    bcur_reg <= '0;
                                    blb_reg  <= '0;
                                end else if (!sel_reg) begin
                                    blen_reg <= alt_len_reg;
                                    bcur_reg <= alt_cur_reg;
                                    blb_reg  <= alt_lb_reg;
                                end
                            end else if (sel_reg) begin
                                blen_reg <= main_len_reg;
                                bcur_reg <= main_cur_reg;
                                blb_reg  <= main_lb_reg;
                            end
                        end
                        CMD_CLEAR: begin
                            blen_reg <= '0;
                            bcur_reg <= '0;
                            blb_reg  <= '0;
                        end
                        CMD_READ: begin
                            if (ridx_reg < blen_reg) begin
                                eng_req_reg <= mk_req(OP_READ, sel_reg, ridx_reg, '0, '0, '0);
                                after_reg   <= ST_RD_DONE;
                                state_reg   <= ST_WAIT;
                            end
                        end
                        default: state_reg <= ST_FINISH;
                    endcase
                end
                ST_WAIT: begin
                    if (eng_rsp.done) begin
                        state_reg <= after_reg;
                    end
                end
                // insert ins_ch_reg at ins_pos_reg, dropping the oldest char if full
                ST_INS: begin
                    if (blen_reg == pos_t'(STORE_SIZE - 1)) begin
                        eng_req_reg <= mk_req(OP_MOVE_DN, sel_reg, pos_t'(1), blen_reg,
                                              pos_t'(1), '0);
                        after_reg   <= ST_INS_DROP;
                        state_reg   <= ST_WAIT;
                    end else begin
                        state_reg <= ST_INS_SHIFT;
                    end
                end
                ST_INS_DROP: begin
                    blen_reg    <= blen_reg - 1'b1;
                    ins_pos_reg <= (ins_pos_reg == '0) ? '0 : ins_pos_reg - 1'b1;
                    state_reg   <= ST_INS_SHIFT;
                end
                ST_INS_SHIFT: begin
                    eng_req_reg <= mk_req(OP_MOVE_UP, sel_reg, ins_pos_reg, blen_reg, '0, '0);
                    after_reg   <= ST_INS_WR;
                    state_reg   <= ST_WAIT;
                end
                ST_INS_WR: begin
                    eng_req_reg <= mk_req(OP_WRITE, sel_reg, ins_pos_reg, '0, '0, ins_ch_reg);
                    blen_reg    <= blen_reg + 1'b1;
                    after_reg   <= ins_ret_reg;
                    state_reg   <= ST_WAIT;
                end
                ST_WR_CHK: begin
                    if (eng_rsp.data == CH_NL) begin
                        ins_pos_reg <= bcur_reg;
                        ins_ret_reg <= ST_WR_INS_DONE;
                        state_reg   <= ST_INS;
                    end else begin
                        eng_req_reg <= mk_req(OP_WRITE, sel_reg, bcur_reg, '0, '0, ch_reg);
                        bcur_reg    <= bcur_reg + 1'b1;
                        after_reg   <= ST_REFRESH;
                        state_reg   <= ST_WAIT;
                    end
                end
                ST_WR_INS_DONE: begin
                    bcur_reg  <= ins_pos_reg + 1'b1;
                    state_reg <= ST_REFRESH;
                end
                ST_WR_APP_DONE: begin
                    bcur_reg  <= blen_reg;
                    state_reg <= ST_REFRESH;
                end
                ST_NL_SCAN: begin
                    if (eng_rsp.pos < blen_reg) begin
                        bcur_reg  <= eng_rsp.pos + 1'b1;
                        blb_reg   <= eng_rsp.pos + 1'b1;
                        state_reg <= ST_FINISH;
                    end else begin
                        ins_pos_reg <= blen_reg;
                        ins_ch_reg  <= CH_NL;
                        ins_ret_reg <= ST_NL_INS_DONE;
                        state_reg   <= ST_INS;
                    end
                end
                ST_NL_INS_DONE: begin
                    bcur_reg  <= ins_pos_reg + 1'b1;
                    blb_reg   <= ins_pos_reg + 1'b1;
                    state_reg <= ST_FINISH;
                end
                ST_BS_DONE: begin
                    blen_reg  <= blen_reg - 1'b1;
                    bcur_reg  <= bcur_reg - 1'b1;
                    state_reg <= ST_REFRESH;
                end
                ST_EL_SCAN: begin
                    if (el_e > el_s) begin
                        s_reg     <= el_s;
                        e_reg     <= el_e;
                        state_reg <= ST_CUT;
                    end else begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_CUT: begin
                    eng_req_reg <= mk_req(OP_MOVE_DN, sel_reg, e_reg, blen_reg, cut_len, '0);
                    after_reg   <= ST_CUT_DONE;
                    state_reg   <= ST_WAIT;
                end
                ST_CUT_DONE: begin
                    blen_reg <= blen_reg - cut_len;
                    if (bcur_reg > e_reg) begin
                        bcur_reg <= bcur_reg - cut_len;
                    end else if (bcur_reg > s_reg) begin
                        bcur_reg <= s_reg;
                    end
                    state_reg <= ST_REFRESH;
                end
                ST_SET_LOOP: begin
                    if (rcnt_reg == '0) begin
                        state_reg <= ST_PLACE;
                    end else begin
                        eng_req_reg <= mk_req(OP_SCAN_FWD, sel_reg, s_reg, blen_reg, '0, '0);
                        after_reg   <= ST_SET_STEP;
                        state_reg   <= ST_WAIT;
                    end
                end
                ST_SET_STEP: begin
                    if (eng_rsp.pos >= blen_reg) begin
                        // row missing: append a line break
                        ins_pos_reg <= blen_reg;
                        ins_ch_reg  <= CH_NL;
                        ins_ret_reg <= ST_SET_APP;
                        state_reg   <= ST_INS;
                    end else begin
                        s_reg     <= eng_rsp.pos + 1'b1;
                        rcnt_reg  <= rcnt_reg - 1'b1;
                        state_reg <= ST_SET_LOOP;
                    end
                end
                ST_SET_APP: begin
                    s_reg     <= blen_reg;
                    rcnt_reg  <= rcnt_reg - 1'b1;
                    state_reg <= ST_SET_LOOP;
                end
                ST_PLACE: begin
                    eng_req_reg <= mk_req(OP_SCAN_FWD, sel_reg, s_reg, blen_reg, '0, '0);
                    after_reg   <= ST_PLACE_DONE;
                    state_reg   <= ST_WAIT;
                end
                ST_PLACE_DONE: begin
                    blb_reg   <= s_reg;
                    bcur_reg  <= s_reg + place_c;
                    state_reg <= ST_FINISH;
                end
                ST_UP_LOOP: begin
                    if (rcnt_reg == '0 || s_reg == '0) begin
                        state_reg <= ST_PLACE;
                    end else if (s_reg == pos_t'(1)) begin
                        s_reg <= '0;
                    end else begin
                        eng_req_reg <= mk_req(OP_READ, sel_reg, s_reg - 1'b1, '0, '0, '0);
                        after_reg   <= ST_UP_CHK;
                        state_reg   <= ST_WAIT;
                    end
                end
                ST_UP_CHK: begin
                    eng_req_reg <= mk_req(OP_SCAN_BACK, sel_reg, up_j, '0, '0, '0);
                    after_reg   <= ST_UP_STEP;
                    state_reg   <= ST_WAIT;
                end
                ST_UP_STEP: begin
                    s_reg     <= eng_rsp.pos;
                    rcnt_reg  <= rcnt_reg - 1'b1;
                    state_reg <= ST_UP_LOOP;
                end
                ST_DN_LOOP: begin
                    if (rcnt_reg == '0) begin
                        state_reg <= ST_PLACE;
                    end else begin
                        eng_req_reg <= mk_req(OP_SCAN_FWD, sel_reg, s_reg, blen_reg, '0, '0);
                        after_reg   <= ST_DN_STEP;
                        state_reg   <= ST_WAIT;
                    end
                end
                ST_DN_STEP: begin
                    if (eng_rsp.pos >= blen_reg) begin
                        state_reg <= ST_PLACE;
                    end else begin
                        s_reg     <= eng_rsp.pos + 1'b1;
                        rcnt_reg  <= rcnt_reg - 1'b1;
                        state_reg <= ST_DN_LOOP;
                    end
                end
                ST_FWD_DONE: begin
                    bcur_reg  <= (fwd_sum > {1'b0, eng_rsp.pos}) ? eng_rsp.pos
                                                                 : fwd_sum[POS_W-1:0];
                    state_reg <= ST_FINISH;
                end
                ST_RD_DONE: begin
                    rd_reg    <= eng_rsp.data;
                    state_reg <= ST_FINISH;
                end
                ST_REFRESH: begin
                    bcur_reg    <= ref_cur;
                    eng_req_reg <= mk_req(OP_SCAN_BACK, sel_reg, ref_cur, '0, '0, '0);
                    after_reg   <= ST_REFRESH_DONE;
                    state_reg   <= ST_WAIT;
                end
                ST_REFRESH_DONE: begin
                    blb_reg   <= eng_rsp.pos;
                    state_reg <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (!m_valid_reg || m_ready) begin
                        if (sel_reg) begin
                            alt_len_reg <= blen_reg;
                            alt_cur_reg <= bcur_reg;
                            alt_lb_reg  <= blb_reg;
                        end else begin
                            main_len_reg <= blen_reg;
                            main_cur_reg <= bcur_reg;
                            main_lb_reg  <= blb_reg;
                        end
                        m_valid_reg <= 1'b1;
                        m_len_reg   <= blen_reg;
                        m_cur_reg   <= bcur_reg;
                        m_lb_reg    <= blb_reg;
                        m_rd_reg    <= rd_reg;
                        m_alt_reg   <= sel_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_length     = m_len_reg;
    assign m_cursor_pos = m_cur_reg;
    assign m_line_begin = m_lb_reg;
    assign m_read_data  = m_rd_reg;
    assign m_alt_active = m_alt_reg;

endmodule

[hw/rtl/ttbe_checker.sv]
// Port-level checks for terminal_text_buffer_editor, attached by bind.
// Uses ttbe_pkg for position widths.
module ttbe_props (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic [ttbe_pkg::POS_W-1:0] m_length,
    input logic [ttbe_pkg::POS_W-1:0] m_cursor_pos,
    input logic [ttbe_pkg::POS_W-1:0] m_line_begin
);
    import ttbe_pkg::*;

    // reset drops any pending result
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // only one request in flight
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while busy");

    // stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_length) && $stable(m_cursor_pos))
        else $error("stalled result changed");

    // cursor stays within the store and after its line start
    a_cursor_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_cursor_pos <= m_length && m_line_begin <= m_cursor_pos)
        else $error("cursor outside store or line");

endmodule

bind terminal_text_buffer_editor ttbe_props u_ttbe_props (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_length     (m_length),
    .m_cursor_pos (m_cursor_pos),
    .m_line_begin (m_line_begin)
);

[bench/ttbe_checker.sv]
// Result checker for the terminal text buffer editor: tracks both stores,
// predicts one result per accepted request and compares. Depends on ttbe_pkg.
`timescale 1ns / 1ps
module ttbe_checker
    import ttbe_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    input  logic         s_ready,
    input  logic [3:0]   s_cmd,
    input  logic [7:0]   s_ch,
    input  logic [1:0]   s_erase_mode,
    input  pos_t         s_row,
    input  pos_t         s_col,
    input  pos_t         s_count,
    input  logic         s_alt_enable,
    input  logic         s_clear_on_enter,
    input  pos_t         s_read_index,
    input  logic         m_valid,
    input  logic         m_ready,
    input  pos_t         m_length,
    input  pos_t         m_cursor_pos,
    input  pos_t         m_line_begin,
    input  logic [7:0]   m_read_data,
    input  logic         m_alt_active,
    output int           fail_count,
    output int           pending
);

    typedef struct packed {
        pos_t       len;
        pos_t       cur;
        pos_t       lb;
        logic [7:0] rd;
        logic       alt;
    } status_t;

    logic [7:0] stores [2][STORE_SIZE];
    int         st_len [2];
    int         st_cur [2];
    int         st_lb  [2];
    int         sel;
    // working copy of the active store
    int         len, cur, lb;
    status_t    expected_q [$];

    function automatic logic [7:0] rdc(int i);
        return stores[sel][i];
    endfunction

    function automatic void find_line_start();
        int i;
        if (cur > len) cur = len;
        i = cur;
        while (i > 0 && rdc(i - 1) != CH_NL) i--;
        lb = i;
    endfunction

    function automatic void drop_oldest();
        if (len == 0) return;
        for (int i = 0; i < len - 1; i++) stores[sel][i] = stores[sel][i + 1];
        len--;
        if (cur > 0) cur--;
        if (lb > 0) lb--;
        find_line_start();
    endfunction

    function automatic int insert_char(int pos, logic [7:0] c);
        int was;
        if (pos > len) pos = len;
        was = len;
        while (len > 0 && len + 1 >= STORE_SIZE) drop_oldest();
        if (was - len >= pos) pos = 0;
        else pos -= was - len;
        if (pos > len) pos = len;
        for (int i = len; i > pos; i--) stores[sel][i] = stores[sel][i - 1];
        stores[sel][pos] = c;
        len++;
        return pos;
    endfunction

    function automatic int end_of_line(int start);
        int i;
        i = start > len ? len : start;
        while (i < len && rdc(i) != CH_NL) i++;
        return i;
    endfunction

    function automatic void remove_span(int s, int e);
        if (e > len) e = len;
        if (e <= s) return;
        for (int i = 0; i < len - e; i++) stores[sel][s + i] = stores[sel][e + i];
        len -= e - s;
    endfunction

    function automatic int line_above(int ls);
        int i;
        if (ls == 0) return 0;
        i = ls - 1;
        if (i > 0 && rdc(i) == CH_NL) i--;
        while (i > 0 && rdc(i - 1) != CH_NL) i--;
        return i;
    endfunction

    function automatic void go_column(int start, int c);
        int w;
        w = end_of_line(start) - start;
        if (w < 0) w = 0;
        if (c > w) c = w;
        lb = start;
        cur = start + c;
    endfunction

    function automatic status_t apply_request(logic [3:0] cmd, logic [7:0] ch,
            logic [1:0] mode, int row, int col, int cnt, logic en, logic clr,
            int ridx);
        int s, e, i, rd;
        status_t r;
        rd = 0;
        if (row == 0) row = 1;
        if (col == 0) col = 1;
        if (cnt == 0) cnt = 1;
        len = st_len[sel];
        cur = st_cur[sel];
        lb = st_lb[sel];
        case (cmd)
            CMD_WRITE: begin
                if (cur < len) begin
                    if (rdc(cur) == CH_NL) cur = insert_char(cur, ch);
                    else stores[sel][cur] = ch;
                    cur++;
                end else begin
                    void'(insert_char(len, ch));
                    cur = len;
                end
                find_line_start();
            end
            CMD_NEWLINE: begin
                e = end_of_line(lb);
                if (e < len && rdc(e) == CH_NL) cur = e + 1;
                else cur = insert_char(e, CH_NL) + 1;
                lb = cur;
            end
            CMD_CR: cur = lb;
            CMD_BACKSPACE: begin
                if (!(cur == 0 || cur <= lb || cur > len)) begin
                    remove_span(cur - 1, cur);
                    cur--;
                    find_line_start();
                end
            end
            CMD_ERASE_DSP: begin
                if (mode >= ERASE_WHOLE) begin
                    len = 0; cur = 0; lb = 0;
                end else begin
                    if (mode == ERASE_TO_CURSOR) begin s = 0; e = cur; end
                    else begin s = cur; e = len; end
                    if (e > len) e = len;
                    if (e > s) begin
                        remove_span(s, e);
                        if (cur > s) cur = s;
                        find_line_start();
                    end
                end
            end
            CMD_ERASE_LN: begin
                i = end_of_line(lb);
                if (mode == ERASE_TO_CURSOR) begin s = lb; e = cur; end
                else if (mode == ERASE_WHOLE) begin s = lb; e = i; end
                else begin s = cur; e = i; end
                if (e > len) e = len;
                if (e > s) begin
                    remove_span(s, e);
                    if (cur > e) cur -= e - s;
                    else if (cur > s) cur = s;
                    find_line_start();
                end
            end
            CMD_SET: begin
                s = 0;
                for (int k = 1; k < row; k++) begin
                    e = end_of_line(s);
                    if (e >= len) begin
                        void'(insert_char(len, CH_NL));
                        s = len;
                    end else s = e + 1;
                end
                go_column(s, col - 1);
            end
            CMD_UP: begin
                i = cur >= lb ? cur - lb : 0;
                s = lb;
                for (int k = 0; k < cnt && s > 0; k++) s = line_above(s);
                go_column(s, i);
            end
            CMD_DOWN: begin
                i = cur >= lb ? cur - lb : 0;
                s = lb;
                for (int k = 0; k < cnt; k++) begin
                    e = end_of_line(s);
                    if (!(e < len && rdc(e) == CH_NL)) break;
                    s = e + 1;
                end
                go_column(s, i);
            end
            CMD_FWD: begin
                e = end_of_line(lb);
                s = cur + cnt;
                cur = s > e ? e : s;
            end
            CMD_BACK: begin
                if (cur > lb) cur = cnt > cur - lb ? lb : cur - cnt;
            end
            CMD_ALT: begin
                st_len[sel] = len; st_cur[sel] = cur; st_lb[sel] = lb;
                if (en) begin
                    if (clr) begin st_len[1] = 0; st_cur[1] = 0; st_lb[1] = 0; end
                    sel = 1;
                end else sel = 0;
                len = st_len[sel]; cur = st_cur[sel]; lb = st_lb[sel];
            end
            CMD_CLEAR: begin
                len = 0; cur = 0; lb = 0;
            end
            CMD_READ: if (ridx < len) rd = rdc(ridx);
            default: ;
        endcase
        st_len[sel] = len; st_cur[sel] = cur; st_lb[sel] = lb;
        r.len = pos_t'(len);
        r.cur = pos_t'(cur);
        r.lb  = pos_t'(lb);
        r.rd  = rd[7:0];
        r.alt = sel[0];
        return r;
    endfunction

    always @(posedge aclk) begin
        status_t got, want;
        if (!aresetn) begin
            for (int k = 0; k < 2; k++) begin
                st_len[k] = 0; st_cur[k] = 0; st_lb[k] = 0;
            end
            sel = 0;
            expected_q.delete();
        end else begin
            if (s_valid && s_ready)
                expected_q.push_back(apply_request(s_cmd, s_ch, s_erase_mode, s_row,
                    s_col, s_count, s_alt_enable, s_clear_on_enter, s_read_index));
            if (m_valid && m_ready) begin
                got = {m_length, m_cursor_pos, m_line_begin, m_read_data, m_alt_active};
                if (expected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) $display("unexpected result %p", got);
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
        end
        pending = expected_q.size();
    end

    initial begin
        fail_count = 0;
        pending = 0;
        sel = 0;
    end

endmodule

[bench/terminal_text_buffer_editor_tb.sv]
// Testbench top for the terminal text buffer editor: clock, reset, request
// stimulus and verdict. Depends on ttbe_pkg, ttbe_checker and the block.
`timescale 1ns / 1ps
module terminal_text_buffer_editor_tb;
    import ttbe_pkg::*;

    logic       aclk = 0;
    logic       aresetn = 0;
    logic       s_valid = 0;
    logic       s_ready;
    logic [3:0] s_cmd = CMD_CR;
    logic [7:0] s_ch = 0;
    logic [1:0] s_erase_mode = 0;
    pos_t       s_row = 0, s_col = 0, s_count = 0, s_read_index = 0;
    logic       s_alt_enable = 0, s_clear_on_enter = 0;
    logic       m_valid;
    logic       m_ready = 0;
    pos_t       m_length, m_cursor_pos, m_line_begin;
    logic [7:0] m_read_data;
    logic       m_alt_active;
    int         fail_count, pending;
    int         send_idle_pct = 0, recv_idle_pct = 0;
    logic       hold_off = 0;

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    terminal_text_buffer_editor dut (.*);

    ttbe_checker checker_i (.*);

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge aclk)
        m_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);

    // the block stays busy in its dispatch and finish states after each request,
    // so waiting for a falling edge after the previous valid drop costs no throughput
    task automatic send(logic [3:0] cmd, logic [7:0] ch = 0, logic [1:0] mode = 0,
            int row = 1, int col = 1, int cnt = 1, logic en = 0, logic clr = 0,
            int ridx = 0);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        s_valid <= 1;
        s_cmd <= cmd; s_ch <= ch; s_erase_mode <= mode;
        s_row <= pos_t'(row); s_col <= pos_t'(col); s_count <= pos_t'(cnt);
        s_alt_enable <= en; s_clear_on_enter <= clr; s_read_index <= pos_t'(ridx);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        s_valid <= 0;
    endtask

    task automatic wait_drained();
        while (pending != 0) @(negedge aclk);
    endtask

    task automatic random_request(int maxrow);
        int pick;
        pick = $urandom_range(99);
        if (pick < 40)
            send(CMD_WRITE, ($urandom_range(9) == 0) ? CH_NL : $urandom_range(255));
        else if (pick < 50) send(CMD_NEWLINE);
        else if (pick < 58)
            send(CMD_SET, 0, 0, $urandom_range(maxrow), $urandom_range(20));
        else if (pick < 62)
            send(CMD_SET, 0, 0, $urandom_range(3), $urandom_range(2047));
        else if (pick < 75)
            send($urandom_range(CMD_UP, CMD_BACK), 0, 0, 1, 1,
                 ($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(4));
        else if (pick < 84)
            send(CMD_READ, 0, 0, 1, 1, 1, 0, 0,
                 ($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(60));
        else if (pick < 88) send(CMD_BACKSPACE);
        else if (pick < 91) send(CMD_ERASE_LN, 0, $urandom_range(3));
        else if (pick < 93) send(CMD_ERASE_DSP, 0, $urandom_range(1));
        else if (pick < 95) send(CMD_CR);
        else if (pick < 97) send(CMD_ALT, 0, 0, 1, 1, 1, $urandom_range(1), $urandom_range(1));
        else if (pick < 98) send(CMD_CLEAR);
        else send($urandom_range(14, 15), $urandom_range(255), $urandom_range(3),
                  $urandom_range(2047), $urandom_range(2047), $urandom_range(2047),
                  $urandom_range(1), $urandom_range(1), $urandom_range(2047));
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        send_idle_pct = 17;
        recv_idle_pct = 79;

        // directed: every command, extremes of the fields
        send(CMD_READ, 0, 0, 1, 1, 1, 0, 0, 2047);
        send(CMD_WRITE, 8'hff);
        send(CMD_WRITE, 8'h00);
        send(CMD_WRITE, CH_NL);
        send(CMD_NEWLINE);
        send(CMD_SET, 0, 0, 5, 2047);
        send(CMD_WRITE, 8'h41);
        send(CMD_SET, 0, 0, 1, 1);
        send(CMD_WRITE, 8'h42);
        send(CMD_UP, 0, 0, 1, 1, 0);
        send(CMD_DOWN, 0, 0, 1, 1, 2047);
        send(CMD_UP, 0, 0, 1, 1, 2047);
        send(CMD_FWD, 0, 0, 1, 1, 2047);
        send(CMD_BACK, 0, 0, 1, 1, 0);
        send(CMD_BACKSPACE);
        send(CMD_CR);
        send(CMD_BACKSPACE);
        send(CMD_ERASE_LN, 0, ERASE_TO_END);
        send(CMD_ERASE_LN, 0, ERASE_WHOLE);
        send(CMD_ERASE_DSP, 0, ERASE_TO_CURSOR);
        send(CMD_READ, 0, 0, 1, 1, 1, 0, 0, 0);
        send(CMD_ALT, 0, 0, 1, 1, 1, 1, 1);
        send(CMD_WRITE, 8'h55);
        send(CMD_ALT, 0, 0, 1, 1, 1, 0, 0);
        send(CMD_ALT, 0, 0, 1, 1, 1, 1, 0);
        send(CMD_ERASE_DSP, 0, ERASE_DISPLAY);
        send(CMD_CLEAR);
        send(4'd15, 8'haa, 2'd3, 2047, 2047, 2047, 1, 1, 2047);

        // long receiver hold-off while requests keep coming
        fork
            begin
                hold_off = 1;
                repeat (400) @(negedge aclk);
                hold_off = 0;
            end
            for (int k = 0; k < 8; k++) send(CMD_WRITE, $urandom_range(255));
        join

        // sender pause until everything has come back
        wait_drained();

        for (int k = 0; k < 85; k++) random_request(8);
        send_idle_pct = 79;
        recv_idle_pct = 17;
        for (int k = 0; k < 85; k++) random_request(8);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int k = 0; k < 55; k++) random_request(8);
        // a far row pads the store with line breaks until it is full;
        // the writes after it drop the oldest characters
        send(CMD_SET, 0, 0, 2047, 1);
        for (int k = 0; k < 12; k++) send(CMD_WRITE, $urandom_range(255));
        send(CMD_NEWLINE);
        send(CMD_SET, 0, 0, 1500, 3);
        for (int k = 0; k < 10; k++) random_request(30);

        wait_drained();
        repeat (5000) @(negedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS terminal_text_buffer_editor");
        end else begin
            $display("FAIL terminal_text_buffer_editor");
        end
        $finish;
    end

    initial begin
        #800ms;
        $display("FAIL terminal_text_buffer_editor");
        $finish;
    end

endmodule
